@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ntm_pkg.sv @@
// types and constants for the nearest template match block
// no dependencies
`default_nettype none

package ntm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int PORT_IDX_W = 6;
    localparam int VAL_W      = 16;
    localparam int NP_W       = 7;
    localparam int SQ_W       = 2 * VAL_W;
    localparam int DIST_W     = SQ_W + 2;

    localparam logic [NP_W-1:0] NP_RESET = NP_W'(1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        val_t a;
        val_t b;
        val_t c;
    } point_t;

    typedef struct packed {
        logic valid;
        logic last;
        idx_t idx;
    } scan_tag_t;

    typedef struct packed {
        scan_tag_t tag;
        dist_t     distance;
    } dist_res_t;

endpackage

`default_nettype wire

@@ rtl/ntm_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ntm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/ntm_dist.sv @@
// pipelined squared euclidean distance unit, one table entry per cycle
// depends on ntm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ntm_dist (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ntm_pkg::scan_tag_t in_tag,
    input  wire ntm_pkg::point_t    query,
    input  wire ntm_pkg::point_t    entry,
    output ntm_pkg::dist_res_t      result
);

    ntm_pkg::scan_tag_t s1_tag_reg, s1_tag_next;
    ntm_pkg::scan_tag_t s2_tag_reg, s2_tag_next;
    ntm_pkg::scan_tag_t s3_tag_reg, s3_tag_next;
    ntm_pkg::point_t    diff_reg, diff_next;
    logic [ntm_pkg::SQ_W-1:0] sq_a_reg, sq_a_next;
    logic [ntm_pkg::SQ_W-1:0] sq_b_reg, sq_b_next;
    logic [ntm_pkg::SQ_W-1:0] sq_c_reg, sq_c_next;
    ntm_pkg::dist_t     dist_reg, dist_next;

    function automatic ntm_pkg::val_t abs_diff(ntm_pkg::val_t x, ntm_pkg::val_t y);
        return (x >= y) ? ntm_pkg::val_t'(x - y) : ntm_pkg::val_t'(y - x);
    endfunction

    always_comb
    begin
        s1_tag_next = in_tag;
        s2_tag_next = s1_tag_reg;
        s3_tag_next = s2_tag_reg;
        diff_next.a = abs_diff(query.a, entry.a);
        diff_next.b = abs_diff(query.b, entry.b);
        diff_next.c = abs_diff(query.c, entry.c);
        sq_a_next   = ntm_pkg::SQ_W'(diff_reg.a) * ntm_pkg::SQ_W'(diff_reg.a);
        sq_b_next   = ntm_pkg::SQ_W'(diff_reg.b) * ntm_pkg::SQ_W'(diff_reg.b);
        sq_c_next   = ntm_pkg::SQ_W'(diff_reg.c) * ntm_pkg::SQ_W'(diff_reg.c);
        dist_next   = ntm_pkg::DIST_W'(sq_a_reg) + ntm_pkg::DIST_W'(sq_b_reg)
                    + ntm_pkg::DIST_W'(sq_c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s2_tag_next;
            s3_tag_reg <= s3_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_a_reg <= sq_a_next;
        sq_b_reg <= sq_b_next;
        sq_c_reg <= sq_c_next;
        dist_reg <= dist_next;
    end

    assign result.tag      = s3_tag_reg;
    assign result.distance = dist_reg;

    `ASSERT_SAME(a_dist_latency, result.tag.valid, $past(in_tag.valid, 3),
        "distance result without matching entry three cycles earlier")
    `ASSERT_SAME(a_dist_last_valid, s3_tag_reg.last, s3_tag_reg.valid,
        "last marker on an empty pipeline slot")
    `ASSERT_NEXT(a_dist_idx_flow, s2_tag_reg.valid, s3_tag_reg.idx == $past(s2_tag_reg.idx),
        "entry index lost between pipeline stages")

endmodule

`default_nettype wire

@@ rtl/nearest_template_match.sv @@
// top level of the nearest template match block: sequencer, table ram and best tracker
// depends on ntm_pkg, ntm_ram, ntm_dist and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// A write transaction (cmd 0) stores one triple in the table and gives no result; busy
// stays low. A query transaction (cmd 1) raises busy, reads the table entries 0 to n-1,
// with n the number of entries in use, one per cycle through the single ram read port,
// and feeds them through the shared distance pipeline (difference, square, sum) and a
// running compare. busy falls in the cycle of the result strobe, so the next transaction
// may start there. result_valid is high for exactly one cycle with nearest_index, and
// the receiver cannot stall it. num_points is written through the cfg port, which is ready
// while idle; a value of zero scans one entry and values above the table size scan the
// whole table.

module nearest_template_match (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           cmd,
    input  wire logic [ntm_pkg::PORT_IDX_W-1:0] entry_index,
    input  wire logic [ntm_pkg::VAL_W-1:0]      value_a,
    input  wire logic [ntm_pkg::VAL_W-1:0]      value_b,
    input  wire logic [ntm_pkg::VAL_W-1:0]      value_c,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ntm_pkg::NP_W-1:0]       cfg_data,
    output logic                                result_valid,
    output logic      [ntm_pkg::PORT_IDX_W-1:0] nearest_index
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;

    logic [ntm_pkg::NP_W-1:0]       num_points_reg, num_points_next;
    logic                           result_valid_reg, result_valid_next;
    logic [ntm_pkg::PORT_IDX_W-1:0] nearest_index_reg, nearest_index_next;
    ntm_pkg::scan_tag_t             rd_tag_reg, rd_tag_next;

    ntm_pkg::point_t query_reg, query_next;
    ntm_pkg::idx_t   addr_reg, addr_next;
    ntm_pkg::idx_t   last_addr_reg, last_addr_next;
    ntm_pkg::idx_t   best_idx_reg, best_idx_next;
    ntm_pkg::dist_t  best_dist_reg, best_dist_next;

    ntm_pkg::point_t    wr_point;
    ntm_pkg::point_t    rd_point;
    ntm_pkg::scan_tag_t issue_tag;
    ntm_pkg::dist_res_t dist_res;
    logic               accept;
    logic               ram_we;
    logic               take;

    function automatic ntm_pkg::idx_t scan_last(logic [ntm_pkg::NP_W-1:0] np);
        ntm_pkg::idx_t last;
        if (np == '0)
        begin
            last = '0;
        end
        else if (int'(np) > ntm_pkg::MAX_POINTS)
        begin
            last = ntm_pkg::idx_t'(ntm_pkg::MAX_POINTS - 1);
        end
        else
        begin
            last = ntm_pkg::idx_t'(np - 1'b1);
        end
        return last;
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && !busy;
    assign ram_we    = accept && (cmd == ntm_pkg::CMD_WRITE)
                    && (int'(entry_index) < ntm_pkg::MAX_POINTS);

    assign wr_point.a = value_a;
    assign wr_point.b = value_b;
    assign wr_point.c = value_c;

    assign issue_tag.valid = (state_reg == S_SCAN);
    assign issue_tag.last  = (state_reg == S_SCAN) && (addr_reg == last_addr_reg);
    assign issue_tag.idx   = addr_reg;

    ntm_ram #(
        .WIDTH ($bits(ntm_pkg::point_t)),
        .DEPTH (ntm_pkg::MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ntm_pkg::idx_t'(entry_index)),
        .wdata (wr_point),
        .raddr (addr_reg),
        .rdata (rd_point)
    );

    ntm_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_tag (rd_tag_reg),
        .query  (query_reg),
        .entry  (rd_point),
        .result (dist_res)
    );

    assign take = (dist_res.tag.idx == '0) || (dist_res.distance < best_dist_reg);

    always_comb
    begin
        state_next         = state_reg;
        num_points_next    = num_points_reg;
        result_valid_next  = 1'b0;
        nearest_index_next = nearest_index_reg;
        rd_tag_next        = issue_tag;
        query_next         = query_reg;
        addr_next          = addr_reg;
        last_addr_next     = last_addr_reg;
        best_idx_next      = best_idx_reg;
        best_dist_next     = best_dist_reg;

        if (cfg_valid && cfg_ready)
        begin
            num_points_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == ntm_pkg::CMD_QUERY))
                begin
                    query_next     = wr_point;
                    addr_next      = '0;
                    last_addr_next = scan_last(num_points_reg);
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == last_addr_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dist_res.tag.valid)
        begin
            if (take)
            begin
                best_idx_next  = dist_res.tag.idx;
                best_dist_next = dist_res.distance;
            end
            if (dist_res.tag.last)
            begin
                result_valid_next  = 1'b1;
                nearest_index_next = take ? ntm_pkg::PORT_IDX_W'(dist_res.tag.idx)
                                          : ntm_pkg::PORT_IDX_W'(best_idx_reg);
                state_next         = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            num_points_reg    <= ntm_pkg::NP_RESET;
            result_valid_reg  <= 1'b0;
            nearest_index_reg <= '0;
            rd_tag_reg        <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            num_points_reg    <= num_points_next;
            result_valid_reg  <= result_valid_next;
            nearest_index_reg <= nearest_index_next;
            rd_tag_reg        <= rd_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        addr_reg      <= addr_next;
        last_addr_reg <= last_addr_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign result_valid  = result_valid_reg;
    assign nearest_index = nearest_index_reg;

    `ASSERT_NEXT(a_query_busy, accept && (cmd == ntm_pkg::CMD_QUERY), busy,
        "query transaction accepted but block not busy")
    `ASSERT_NEXT(a_single_strobe, result_valid_reg, !result_valid_reg,
        "result strobe longer than one cycle")
    `ASSERT_SAME(a_dist_while_busy, dist_res.tag.valid, busy,
        "distance result arrived while idle")
    `ASSERT_SAME(a_no_write_busy, ram_we, !busy,
        "table written during a scan")

endmodule

`default_nettype wire

@@ bench/nearest_template_match_tb.sv @@
// self-checking testbench for nearest_template_match: directed and random traffic
// a local nearest-entry predictor runs beside the block and compares each result
// depends on ntm_pkg and the nearest_template_match rtl
module nearest_template_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = ntm_pkg::MAX_POINTS + 8;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cmd;
    logic [ntm_pkg::PORT_IDX_W-1:0] entry_index;
    ntm_pkg::val_t value_a;
    ntm_pkg::val_t value_b;
    ntm_pkg::val_t value_c;
    logic cfg_valid;
    logic cfg_ready;
    logic [ntm_pkg::NP_W-1:0] cfg_data;
    logic result_valid;
    logic [ntm_pkg::PORT_IDX_W-1:0] nearest_index;

    // predictor state
    ntm_pkg::point_t point_mirror [ntm_pkg::MAX_POINTS];
    logic [ntm_pkg::NP_W-1:0] points_in_use;
    logic [ntm_pkg::PORT_IDX_W-1:0] expected_nearest [$];

    // stimulus side bookkeeping
    logic [ntm_pkg::MAX_POINTS-1:0] loaded_entries;
    logic [ntm_pkg::NP_W-1:0] chosen_points;
    int idle_pct;
    int error_count;
    int queries_checked;
    int writes_sent;
    int count_settings;
    int stall_cycles;

    nearest_template_match uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .entry_index   (entry_index),
        .value_a       (value_a),
        .value_b       (value_b),
        .value_c       (value_c),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .nearest_index (nearest_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int scan_len(input logic [ntm_pkg::NP_W-1:0] np);
        int n;
        n = int'(np);
        if (n == 0)
            n = 1;
        if (n > ntm_pkg::MAX_POINTS)
            n = ntm_pkg::MAX_POINTS;
        return n;
    endfunction

    function automatic ntm_pkg::dist_t sq_gap(input ntm_pkg::val_t x, input ntm_pkg::val_t y);
        ntm_pkg::dist_t g;
        g = (x >= y) ? ntm_pkg::dist_t'(x - y) : ntm_pkg::dist_t'(y - x);
        return g * g;
    endfunction

    function automatic logic [ntm_pkg::PORT_IDX_W-1:0] nearest_entry(
        input ntm_pkg::val_t qa, input ntm_pkg::val_t qb, input ntm_pkg::val_t qc,
        input logic [ntm_pkg::NP_W-1:0] np);
        int n;
        int best;
        ntm_pkg::dist_t best_d;
        ntm_pkg::dist_t d;
        n = scan_len(np);
        best = 0;
        best_d = '0;
        for (int i = 0; i < n; i++)
        begin
            d = sq_gap(qa, point_mirror[i].a) + sq_gap(qb, point_mirror[i].b)
              + sq_gap(qc, point_mirror[i].c);
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        return ntm_pkg::PORT_IDX_W'(best);
    endfunction

    function automatic ntm_pkg::val_t jitter(input ntm_pkg::val_t v, input int spread);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return ntm_pkg::val_t'(t);
    endfunction

    function automatic ntm_pkg::val_t rail_value();
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch: %s, expected %0d got %0d at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // result check, point-count capture, then acceptance of the transaction in the same edge
    always @(posedge clk)
    begin
        logic [ntm_pkg::PORT_IDX_W-1:0] want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_nearest.size() == 0)
                    report_mismatch("result with no query pending", -1, nearest_index);
                else
                begin
                    want = expected_nearest.pop_front();
                    if (nearest_index !== want)
                        report_mismatch("nearest_index", want, nearest_index);
                    queries_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                points_in_use = cfg_data;
            if (start && !busy)
            begin
                if (cmd == ntm_pkg::CMD_WRITE)
                    point_mirror[entry_index] = {value_a, value_b, value_c};
                else
                    expected_nearest.push_back(nearest_entry(value_a, value_b, value_c,
                                                             points_in_use));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [ntm_pkg::PORT_IDX_W-1:0] idx,
                             input ntm_pkg::val_t va, input ntm_pkg::val_t vb,
                             input ntm_pkg::val_t vc);
        @(negedge clk);
        start = 1'b1;
        cmd = op;
        entry_index = idx;
        value_a = va;
        value_b = vb;
        value_c = vc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == ntm_pkg::CMD_WRITE)
        begin
            loaded_entries[idx] = 1'b1;
            writes_sent++;
        end
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 3))
                @(negedge clk);
        end
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        start = 1'b0;
        while (expected_nearest.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_point_count(input logic [ntm_pkg::NP_W-1:0] np);
        wait_until_drained();
        cfg_valid = 1'b1;
        cfg_data = np;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        chosen_points = np;
        count_settings++;
    endtask

    task automatic fill_entries(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (!loaded_entries[i])
                send_item(ntm_pkg::CMD_WRITE, ntm_pkg::PORT_IDX_W'(i),
                          ntm_pkg::val_t'($urandom), ntm_pkg::val_t'($urandom),
                          ntm_pkg::val_t'($urandom));
        end
    endtask

    task automatic send_random_item(input int span);
        int pick;
        int kind;
        int src;
        logic [ntm_pkg::PORT_IDX_W-1:0] idx;
        ntm_pkg::val_t va;
        ntm_pkg::val_t vb;
        ntm_pkg::val_t vc;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 3);
        src = $urandom_range(0, span - 1);
        idx = $urandom_range(0, 1)
            ? ntm_pkg::PORT_IDX_W'($urandom_range(0, ntm_pkg::MAX_POINTS - 1))
            : ntm_pkg::PORT_IDX_W'($urandom_range(0, span - 1));
        case (kind)
            0:
            begin
                va = jitter(point_mirror[src].a, (pick < 35) ? 64 : 300);
                vb = jitter(point_mirror[src].b, (pick < 35) ? 64 : 300);
                vc = jitter(point_mirror[src].c, (pick < 35) ? 64 : 300);
            end
            1:
            begin
                // exact copy: duplicates in the table and zero-distance queries
                va = point_mirror[src].a;
                vb = point_mirror[src].b;
                vc = point_mirror[src].c;
            end
            2:
            begin
                va = rail_value();
                vb = rail_value();
                vc = rail_value();
            end
            default:
            begin
                va = ntm_pkg::val_t'($urandom);
                vb = ntm_pkg::val_t'($urandom);
                vc = ntm_pkg::val_t'($urandom);
            end
        endcase
        if (pick < 35)
            send_item(ntm_pkg::CMD_WRITE, idx, va, vb, vc);
        else
            send_item(ntm_pkg::CMD_QUERY, idx, va, vb, vc);
    endtask

    task automatic test_reset_state();
        send_item(ntm_pkg::CMD_WRITE, 6'd0, 16'h0000, 16'h0000, 16'h0000);
        send_item(ntm_pkg::CMD_QUERY, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ntm_pkg::CMD_QUERY, 6'd0, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_extreme_values();
        write_point_count(7'd4);
        send_item(ntm_pkg::CMD_WRITE, 6'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ntm_pkg::CMD_WRITE, 6'd2, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(ntm_pkg::CMD_WRITE, 6'd3, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(ntm_pkg::CMD_QUERY, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ntm_pkg::CMD_QUERY, 6'd42, 16'h0000, 16'h0000, 16'h0000);
        send_item(ntm_pkg::CMD_QUERY, 6'd21, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(ntm_pkg::CMD_QUERY, 6'd63, 16'h0000, 16'hFFFF, 16'h0001);
    endtask

    task automatic test_ties();
        send_item(ntm_pkg::CMD_WRITE, 6'd2, 16'd100, 16'd200, 16'd300);
        send_item(ntm_pkg::CMD_WRITE, 6'd3, 16'd100, 16'd200, 16'd300);
        send_item(ntm_pkg::CMD_QUERY, 6'd0, 16'd100, 16'd200, 16'd300);
        send_item(ntm_pkg::CMD_WRITE, 6'd0, 16'd1000, 16'd1000, 16'd1000);
        send_item(ntm_pkg::CMD_WRITE, 6'd1, 16'd1002, 16'd1000, 16'd1000);
        send_item(ntm_pkg::CMD_QUERY, 6'd0, 16'd1001, 16'd1000, 16'd1000);
    endtask

    task automatic test_zero_count();
        // zero scans entry 0 only, even though other entries are closer
        write_point_count(7'd0);
        send_item(ntm_pkg::CMD_QUERY, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        logic [ntm_pkg::NP_W-1:0] forced_counts [5];
        logic [ntm_pkg::NP_W-1:0] np;
        int span;
        forced_counts = '{7'd127, 7'd0, 7'd64, 7'd65, 7'd1};
        for (int chunk = 0; chunk < 20; chunk++)
        begin
            if (chunk < 5)
                np = forced_counts[chunk];
            else if ($urandom_range(0, 3) == 0)
                np = ntm_pkg::NP_W'($urandom_range(0, 127));
            else
                np = ntm_pkg::NP_W'($urandom_range(1, 16));
            idle_pct = 0;
            write_point_count(np);
            span = scan_len(np);
            fill_entries(span);
            idle_pct = (chunk < 7) ? 12 : (chunk < 14) ? 57 : 0;
            for (int k = 0; k < 100; k++)
                send_random_item(span);
        end
        idle_pct = 0;
    endtask

    task automatic test_count_saturation();
        write_point_count(7'd127);
        fill_entries(ntm_pkg::MAX_POINTS);
        for (int k = 0; k < 10; k++)
            send_random_item(ntm_pkg::MAX_POINTS);
        write_point_count(7'd65);
        for (int k = 0; k < 10; k++)
            send_random_item(ntm_pkg::MAX_POINTS);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = ntm_pkg::CMD_WRITE;
        entry_index = '0;
        value_a = '0;
        value_b = '0;
        value_c = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        points_in_use = ntm_pkg::NP_RESET;
        chosen_points = ntm_pkg::NP_RESET;
        loaded_entries = '0;
        idle_pct = 0;
        error_count = 0;
        queries_checked = 0;
        writes_sent = 0;
        count_settings = 0;
        for (int i = 0; i < ntm_pkg::MAX_POINTS; i++)
            point_mirror[i] = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_extreme_values();
        test_ties();
        test_zero_count();
        test_random_traffic();
        test_count_saturation();

        wait_until_drained();
        $display("covered %0d checked queries, %0d table writes, %0d point-count settings",
                 queries_checked, writes_sent, count_settings);
        $display("point counts from 0 to 127, sender gaps at 12 and 57 percent and none");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ntm_pkg.sv
rtl/ntm_ram.sv
rtl/ntm_dist.sv
rtl/nearest_template_match.sv
bench/nearest_template_match_tb.sv
